// ===== rtl/core/lz4sp_pkg.sv =====
package lz4sp_pkg;

  localparam int unsigned PosW    = 16;
  localparam int unsigned LitW    = 9;
  localparam int unsigned MatchW  = 10;
  localparam int unsigned RunW    = 5;
  localparam int unsigned SeqW    = 7;

  localparam logic [3:0]        NIBBLE_EXT  = 4'hF;
  localparam logic [7:0]        RUN_BYTE    = 8'hFF;
  localparam logic [7:0]        RUN_ADD     = 8'd15;
  localparam logic [MatchW-1:0] MATCH_BASE  = 10'd4;
  localparam logic [LitW-1:0]   LIT_MAX     = 9'h1FF;
  localparam logic [MatchW-1:0] MATCH_MAX   = 10'h3FF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  // Byte as handed from the front end to the parser: tagged with its position
  // and with the end-of-block mark already resolved.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic            last;
    logic [PosW-1:0] pos;
  } tag_item_t;

  typedef struct packed {
    logic              seq_found;
    logic [PosW-1:0]   token_position;
    logic [LitW-1:0]   literal_length;
    logic [MatchW-1:0] match_length;
    logic [PosW-1:0]   match_offset;
    logic              stream_done;
  } out_item_t;

endpackage

// ===== rtl/core/lz4sp_fifo.sv =====
module lz4sp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/lz4sp_front.sv =====
module lz4sp_front #(
  parameter int unsigned BLOCK_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lz4sp_pkg::in_item_t   item_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output lz4sp_pkg::tag_item_t  q_item_o
);
  import lz4sp_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_BYTES - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            accept, last_eff;

  assign accept   = push_i && !q_full_i;
  // Force the end of block at the last position that fits.
  assign last_eff = item_i.is_last || (pos_q == LastPos);

  assign q_push_o           = accept;
  assign q_item_o.data_byte = item_i.data_byte;
  assign q_item_o.last      = last_eff;
  assign q_item_o.pos       = pos_q;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = last_eff ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== rtl/core/lz4sp_back.sv =====
module lz4sp_back #(
  parameter int unsigned EXT_CAP  = 16,
  parameter int unsigned MAX_SEQS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  lz4sp_pkg::tag_item_t  q_item_i,
  output logic                  q_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output lz4sp_pkg::out_item_t  res_item_o
);
  import lz4sp_pkg::*;

  localparam int unsigned PhW = 3;
  localparam logic [PhW-1:0] PH_TOKEN     = 3'd0;
  localparam logic [PhW-1:0] PH_LIT_EXT   = 3'd1;
  localparam logic [PhW-1:0] PH_LIT_SKIP  = 3'd2;
  localparam logic [PhW-1:0] PH_OFF_LO    = 3'd3;
  localparam logic [PhW-1:0] PH_OFF_HI    = 3'd4;
  localparam logic [PhW-1:0] PH_MATCH_EXT = 3'd5;
  localparam logic [PhW-1:0] PH_STOPPED   = 3'd6;

  localparam logic [RunW-1:0] ExtCap  = RunW'(EXT_CAP);
  localparam logic [SeqW-1:0] MaxSeqs = SeqW'(MAX_SEQS);

  logic [PhW-1:0]    phase_q, phase_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [LitW-1:0]   lit_q, lit_d;
  logic [MatchW-1:0] match_q, match_d;
  logic [3:0]        nib_q, nib_d;
  logic [PosW-1:0]   off_q, off_d;
  logic [LitW-1:0]   skip_q, skip_d;
  logic [PosW-1:0]   tok_q, tok_d;
  logic [SeqW-1:0]   seqs_q, seqs_d;

  logic              consume, complete, is_run;
  logic [7:0]        b, add_val;
  logic [LitW:0]     lit_sum;
  logic [MatchW:0]   match_sum;
  logic [LitW-1:0]   lit_sat;
  logic [MatchW-1:0] match_sat;
  logic [3:0]        lit_nib;

  assign consume = !q_empty_i && !res_full_i;
  assign q_pop_o = consume;
  assign b       = q_item_i.data_byte;
  assign lit_nib = b[7:4];

  // Extension run byte while the run budget lasts adds 15, else the byte itself.
  assign is_run    = (b == RUN_BYTE) && (run_q < ExtCap);
  assign add_val   = is_run ? RUN_ADD : b;
  assign lit_sum   = {1'b0, lit_q} + (LitW + 1)'(add_val);
  assign match_sum = {1'b0, match_q} + (MatchW + 1)'(add_val);
  assign lit_sat   = lit_sum[LitW] ? LIT_MAX : lit_sum[LitW-1:0];
  assign match_sat = match_sum[MatchW] ? MATCH_MAX : match_sum[MatchW-1:0];

  always_comb begin
    phase_d  = phase_q;
    run_d    = run_q;
    lit_d    = lit_q;
    match_d  = match_q;
    nib_d    = nib_q;
    off_d    = off_q;
    skip_d   = skip_q;
    tok_d    = tok_q;
    seqs_d   = seqs_q;
    complete = 1'b0;

    case (phase_q)
      PH_TOKEN: begin
        tok_d   = q_item_i.pos;
        nib_d   = b[3:0];
        match_d = MATCH_BASE + MatchW'(b[3:0]);
        lit_d   = LitW'(lit_nib);
        run_d   = '0;
        off_d   = '0;
        if (lit_nib == NIBBLE_EXT) begin
          phase_d = PH_LIT_EXT;
        end else begin
          skip_d  = LitW'(lit_nib);
          phase_d = (lit_nib != '0) ? PH_LIT_SKIP : PH_OFF_LO;
        end
      end
      PH_LIT_EXT: begin
        lit_d = lit_sat;
        if (is_run) begin
          run_d = run_q + 1'b1;
        end else begin
          skip_d  = lit_sat;
          phase_d = (lit_sat != '0) ? PH_LIT_SKIP : PH_OFF_LO;
        end
      end
      PH_LIT_SKIP: begin
        skip_d = skip_q - 1'b1;
        if (skip_q == LitW'(1)) begin
          phase_d = PH_OFF_LO;
        end
      end
      PH_OFF_LO: begin
        off_d   = PosW'(b);
        phase_d = PH_OFF_HI;
      end
      PH_OFF_HI: begin
        off_d = {b, off_q[7:0]};
        if (nib_q == NIBBLE_EXT) begin
          run_d   = '0;
          phase_d = PH_MATCH_EXT;
        end else begin
          complete = 1'b1;
        end
      end
      PH_MATCH_EXT: begin
        match_d = match_sat;
        if (is_run) begin
          run_d = run_q + 1'b1;
        end else begin
          complete = 1'b1;
        end
      end
      default: begin
        // stopped: hold until the end of block
      end
    endcase

    if (complete) begin
      seqs_d  = seqs_q + 1'b1;
      phase_d = (seqs_d >= MaxSeqs) ? PH_STOPPED : PH_TOKEN;
    end

    res_item_o.seq_found      = complete;
    res_item_o.token_position = complete ? tok_d : '0;
    res_item_o.literal_length = complete ? lit_d : '0;
    res_item_o.match_length   = complete ? match_d : '0;
    res_item_o.match_offset   = complete ? off_d : '0;
    res_item_o.stream_done    = q_item_i.last;

    if (q_item_i.last) begin
      phase_d = PH_TOKEN;
      run_d   = '0;
      lit_d   = '0;
      match_d = '0;
      nib_d   = '0;
      off_d   = '0;
      skip_d  = '0;
      tok_d   = '0;
      seqs_d  = '0;
    end
  end

  assign res_push_o = consume && (complete || q_item_i.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      run_q   <= '0;
      lit_q   <= '0;
      match_q <= '0;
      nib_q   <= '0;
      off_q   <= '0;
      skip_q  <= '0;
      tok_q   <= '0;
      seqs_q  <= '0;
    end else if (consume) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      lit_q   <= lit_d;
      match_q <= match_d;
      nib_q   <= nib_d;
      off_q   <= off_d;
      skip_q  <= skip_d;
      tok_q   <= tok_d;
      seqs_q  <= seqs_d;
    end
  end

  a_skip_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LIT_SKIP) |-> (skip_q != '0))
    else $error("literal skip phase with zero count");

  a_seq_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seqs_q <= MaxSeqs))
    else $error("sequence count beyond limit");

  a_last_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && q_item_i.last) |=> (phase_q == PH_TOKEN && seqs_q == '0))
    else $error("end of block did not restart the parser");

  a_stopped_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STOPPED && res_push_o) |-> (!res_item_o.seq_found))
    else $error("sequence reported after the limit");

endmodule

// ===== rtl/core/lz4_sequence_header_parser.sv =====
// LZ4 block sequence parser. Feed the bytes of one compressed block, one per
// push, with is_last set on the final byte; a block also ends by itself at
// byte BLOCK_BYTES-1. For every sequence the parser decodes the token, the
// literal-length extension (at most EXT_CAP 0xFF run bytes plus one closing
// byte), skips the literals, reads the little-endian offset and the
// match-length extension, and pushes one result carrying the token position,
// literal length, match length and offset. The final byte always produces a
// result with stream_done set (zero sequence fields unless that same byte
// closed a sequence); a sequence still open at that point is dropped. After
// MAX_SEQS sequences the parser goes quiet until the end of the block. It
// takes one byte per clock while neither queue is full. A byte's result, if
// any, passes through the tag queue and then the result queue on its way to
// the output: the front end stamps position and end-of-block into a two-entry
// queue, and the parser state machine consumes one queued byte per cycle
// into a two-entry result queue while that queue has room. Either side may
// stall without stopping the other until its queue fills.
module lz4_sequence_header_parser #(
  parameter int unsigned EXT_CAP     = 16,
  parameter int unsigned MAX_SEQS    = 64,
  parameter int unsigned BLOCK_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte side
  input  logic                  push,
  output logic                  full,
  input  lz4sp_pkg::in_item_t   in_data_i,
  // result side
  output logic                  empty,
  input  logic                  pop,
  output lz4sp_pkg::out_item_t  out_data_o
);
  import lz4sp_pkg::*;

  localparam int unsigned QDepth = 2;

  tag_item_t tag_wr, tag_rd;
  out_item_t res_wr;
  logic      tag_push, tag_full, tag_pop, tag_empty;
  logic      res_push, res_full;

  // Front end: stamp each byte with its position and resolve end of block.
  lz4sp_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_data_i),
    .q_full_i (tag_full),
    .q_push_o (tag_push),
    .q_item_o (tag_wr)
  );

  // Decouple byte intake from the parser.
  lz4sp_fifo #(
    .WIDTH ($bits(tag_item_t)),
    .DEPTH (QDepth)
  ) u_tag_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tag_push),
    .wdata_i (tag_wr),
    .full_o  (tag_full),
    .pop_i   (tag_pop),
    .rdata_o (tag_rd),
    .empty_o (tag_empty)
  );

  // Hold off new bytes only when the tag queue is full.
  assign full = tag_full;

  // Back end: sequence state machine, one byte per cycle while its queues allow.
  lz4sp_back #(
    .EXT_CAP  (EXT_CAP),
    .MAX_SEQS (MAX_SEQS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (tag_empty),
    .q_item_i   (tag_rd),
    .q_pop_o    (tag_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_item_o (res_wr)
  );

  // Result queue: waiting results block the parser only once this queue is full.
  lz4sp_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lz4sp_pkg::*;

  localparam int unsigned EXT_CAP     = 16;
  localparam int unsigned MAX_SEQS    = 64;
  localparam int unsigned BLOCK_BYTES = 65536;

  // Parse phases of the header decoder, mirrored on the testbench side.
  typedef enum logic [2:0] {
    SEEK_TOKEN,
    LIT_EXTEND,
    LIT_SKIP,
    OFFSET_LO,
    OFFSET_HI,
    MATCH_EXTEND,
    HALTED
  } hdr_phase_e;

  // One row of the directed table. When typed is set, the row carries its
  // own expected outcome instead of asking the decoder model.
  typedef struct {
    in_item_t  stim;
    bit        typed;
    bit        has_hdr;
    out_item_t hdr;
  } dir_row_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push;
  logic      full;
  in_item_t  in_data_i;
  logic      empty;
  logic      pop;
  out_item_t out_data_o;

  lz4_sequence_header_parser #(
    .EXT_CAP    (EXT_CAP),
    .MAX_SEQS   (MAX_SEQS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder model state.
  hdr_phase_e        m_phase;
  logic [RunW-1:0]   m_runs;
  logic [LitW-1:0]   m_lit;
  logic [MatchW-1:0] m_match;
  logic [3:0]        m_nibble;
  logic [PosW-1:0]   m_offset;
  logic [LitW-1:0]   m_skip;
  logic [PosW-1:0]   m_pos;
  logic [PosW-1:0]   m_token_pos;
  logic [SeqW-1:0]   m_seqs;

  out_item_t   pending_headers[$];  // headers still owed by the block, oldest first
  dir_row_t    dir_rows[$];
  logic [7:0]  blk_bytes[$];        // bytes of the block under construction

  bit          calm;                // suppress idling on both sides
  int unsigned errors      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned seqs_seen   = 0;
  int unsigned dones_seen  = 0;
  out_item_t   got_hdr;
  out_item_t   want_hdr;

  function automatic void clear_decoder();
    m_phase     = SEEK_TOKEN;
    m_runs      = '0;
    m_lit       = '0;
    m_match     = '0;
    m_nibble    = '0;
    m_offset    = '0;
    m_skip      = '0;
    m_pos       = '0;
    m_token_pos = '0;
    m_seqs      = '0;
  endfunction

  // Advance the decoder model by one byte; report the header it yields, if any.
  function automatic void decode_header_byte(input in_item_t it, output bit has_hdr,
                                             output out_item_t hdr);
    logic [7:0]  b;
    bit          last;
    bit          closed;
    int unsigned sum;
    b      = it.data_byte;
    last   = it.is_last;
    closed = 1'b0;
    // Force the end of the block at its last possible position.
    if (m_pos == PosW'(BLOCK_BYTES - 1)) last = 1'b1;
    case (m_phase)
      SEEK_TOKEN: begin
        m_token_pos = m_pos;
        m_nibble    = b[3:0];
        m_match     = MatchW'(b[3:0]) + MATCH_BASE;
        m_lit       = LitW'(b[7:4]);
        m_runs      = '0;
        m_offset    = '0;
        if (b[7:4] == NIBBLE_EXT) begin
          m_phase = LIT_EXTEND;
        end else begin
          m_skip  = m_lit;
          m_phase = (m_skip != 0) ? LIT_SKIP : OFFSET_LO;
        end
      end
      LIT_EXTEND: begin
        if (b == RUN_BYTE && m_runs < EXT_CAP) begin
          m_runs = m_runs + 1'b1;
          sum    = m_lit + RUN_ADD;
          m_lit  = (sum > LIT_MAX) ? LIT_MAX : LitW'(sum);
        end else begin
          sum     = m_lit + b;
          m_lit   = (sum > LIT_MAX) ? LIT_MAX : LitW'(sum);
          m_skip  = m_lit;
          m_phase = (m_skip != 0) ? LIT_SKIP : OFFSET_LO;
        end
      end
      LIT_SKIP: begin
        m_skip = m_skip - 1'b1;
        if (m_skip == 0) m_phase = OFFSET_LO;
      end
      OFFSET_LO: begin
        m_offset = {8'h00, b};
        m_phase  = OFFSET_HI;
      end
      OFFSET_HI: begin
        m_offset[15:8] = b;
        if (m_nibble == NIBBLE_EXT) begin
          m_runs  = '0;
          m_phase = MATCH_EXTEND;
        end else begin
          closed = 1'b1;
        end
      end
      MATCH_EXTEND: begin
        if (b == RUN_BYTE && m_runs < EXT_CAP) begin
          m_runs  = m_runs + 1'b1;
          sum     = m_match + RUN_ADD;
          m_match = (sum > MATCH_MAX) ? MATCH_MAX : MatchW'(sum);
        end else begin
          sum     = m_match + b;
          m_match = (sum > MATCH_MAX) ? MATCH_MAX : MatchW'(sum);
          closed  = 1'b1;
        end
      end
      default: ;
    endcase
    if (closed) begin
      m_seqs  = m_seqs + 1'b1;
      m_phase = (m_seqs >= MAX_SEQS) ? HALTED : SEEK_TOKEN;
    end
    m_pos   = m_pos + 1'b1;
    has_hdr = closed || last;
    hdr     = '0;
    if (closed) begin
      hdr.seq_found      = 1'b1;
      hdr.token_position = m_token_pos;
      hdr.literal_length = m_lit;
      hdr.match_length   = m_match;
      hdr.match_offset   = m_offset;
    end
    hdr.stream_done = last;
    if (last) clear_decoder();
  endfunction

  function automatic out_item_t mk_hdr(input bit found, input int unsigned pos,
                                       input int unsigned lit, input int unsigned match,
                                       input int unsigned off, input bit done);
    out_item_t h;
    h.seq_found      = found;
    h.token_position = PosW'(pos);
    h.literal_length = LitW'(lit);
    h.match_length   = MatchW'(match);
    h.match_offset   = PosW'(off);
    h.stream_done    = done;
    return h;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit last, input bit typed,
                                  input bit has_hdr, input out_item_t hdr);
    dir_row_t r;
    r.stim.data_byte = b;
    r.stim.is_last   = last;
    r.typed          = typed;
    r.has_hdr        = has_hdr;
    r.hdr            = hdr;
    dir_rows.push_back(r);
  endfunction

  // Append an extension (0xFF run plus closing byte); return the value it adds.
  // A costly extension keeps its closing byte small, since it sizes the literals.
  function automatic int unsigned append_ext(input bit biggest, input bit costly);
    int unsigned runs;
    int unsigned r;
    logic [7:0]  closing;
    r = $urandom_range(19);
    if (biggest)     runs = EXT_CAP;
    else if (r < 12) runs = 0;
    else if (r < 18) runs = $urandom_range(3, 1);
    else             runs = EXT_CAP;
    if (biggest)              closing = RUN_BYTE;
    else if (runs == EXT_CAP) closing = costly ? 8'($urandom_range(20)) : 8'($urandom_range(255));
    else                      closing = costly ? 8'($urandom_range(30)) : 8'($urandom_range(254));
    repeat (runs) blk_bytes.push_back(RUN_BYTE);
    blk_bytes.push_back(closing);
    return runs * RUN_ADD + closing;
  endfunction

  // Append one well-formed sequence header with random content.
  function automatic void build_sequence(input bit biggest);
    logic [3:0]  lit_nib;
    logic [3:0]  match_nib;
    int unsigned lit;
    lit_nib   = biggest ? NIBBLE_EXT
              : (($urandom_range(3) == 0) ? NIBBLE_EXT : 4'($urandom_range(14)));
    match_nib = biggest ? NIBBLE_EXT : 4'($urandom_range(15));
    blk_bytes.push_back({lit_nib, match_nib});
    lit = lit_nib;
    if (lit_nib == NIBBLE_EXT) lit += append_ext(1'b0, 1'b1);
    repeat (lit) blk_bytes.push_back(8'($urandom_range(255)));
    blk_bytes.push_back(8'($urandom_range(255)));
    blk_bytes.push_back(8'($urandom_range(255)));
    if (match_nib == NIBBLE_EXT) void'(append_ext(biggest, 1'b0));
  endfunction

  // Append a sequence with at most one literal and no extensions.
  function automatic void build_short_sequence();
    logic [3:0] lit_nib;
    lit_nib = 4'($urandom_range(1));
    blk_bytes.push_back({lit_nib, 4'($urandom_range(14))});
    repeat (lit_nib) blk_bytes.push_back(8'($urandom_range(255)));
    blk_bytes.push_back(8'($urandom_range(255)));
    blk_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Build a random block: mostly complete sequences, some with a truncated
  // trailing sequence, some pure noise.
  function automatic void make_block();
    int unsigned style;
    int unsigned keep;
    int unsigned cut;
    blk_bytes.delete();
    style = $urandom_range(9);
    if (style >= 8) begin
      repeat ($urandom_range(12, 1)) blk_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(4, 1)) build_sequence(1'b0);
      if (style >= 5) begin
        keep = blk_bytes.size();
        build_sequence(1'b0);
        cut = $urandom_range(blk_bytes.size() - keep - 1, 1);
        repeat (cut) void'(blk_bytes.pop_back());
      end
    end
  endfunction

  // Offer one byte, hold it until the transfer, then log the owed header.
  task automatic send_byte(input in_item_t it, input bit typed, input bit t_has,
                           input out_item_t t_hdr);
    bit        has_hdr;
    out_item_t hdr;
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push      <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (full);
    decode_header_byte(it, has_hdr, hdr);
    if (typed) begin
      has_hdr = t_has;
      hdr     = t_hdr;
    end
    if (has_hdr) pending_headers.push_back(hdr);
    bytes_sent++;
  endtask

  // Send the block under construction; without the end mark the block must
  // end by itself at its size limit.
  task automatic send_block(input bit mark_end);
    in_item_t it;
    for (int unsigned i = 0; i < blk_bytes.size(); i++) begin
      it.data_byte = blk_bytes[i];
      it.is_last   = mark_end && (i == blk_bytes.size() - 1);
      send_byte(it, 1'b0, 1'b0, '0);
    end
  endtask

  // Drop push and hold off until every owed header has been popped.
  task automatic drain_headers();
    push <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check each popped header against the oldest owed one.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got_hdr = out_data_o;
        if (got_hdr.seq_found === 1'b1) seqs_seen++;
        if (got_hdr.stream_done === 1'b1) dones_seen++;
        if (pending_headers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected header found=%b pos=%0d lit=%0d match=%0d off=%h done=%b",
                     $realtime, got_hdr.seq_found, got_hdr.token_position,
                     got_hdr.literal_length, got_hdr.match_length, got_hdr.match_offset,
                     got_hdr.stream_done);
        end else begin
          want_hdr = pending_headers.pop_front();
          if (got_hdr.seq_found      !== want_hdr.seq_found      ||
              got_hdr.token_position !== want_hdr.token_position ||
              got_hdr.literal_length !== want_hdr.literal_length ||
              got_hdr.match_length   !== want_hdr.match_length   ||
              got_hdr.match_offset   !== want_hdr.match_offset   ||
              got_hdr.stream_done    !== want_hdr.stream_done) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: header mismatch", $realtime);
              $display("  expected found=%b pos=%0d lit=%0d match=%0d off=%h done=%b",
                       want_hdr.seq_found, want_hdr.token_position, want_hdr.literal_length,
                       want_hdr.match_length, want_hdr.match_offset, want_hdr.stream_done);
              $display("  actual   found=%b pos=%0d lit=%0d match=%0d off=%h done=%b",
                       got_hdr.seq_found, got_hdr.token_position, got_hdr.literal_length,
                       got_hdr.match_length, got_hdr.match_offset, got_hdr.stream_done);
            end
          end
        end
      end
      // Stall the pop side now and then, except in calm stretches.
      pop <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Stimulus side.
  initial begin
    int unsigned rand_bytes;
    bit          paused;
    bit          biggest_done;
    push         = 1'b0;
    in_data_i    = '0;
    calm         = 1'b0;
    rand_bytes   = 0;
    paused       = 1'b0;
    biggest_done = 1'b0;
    clear_decoder();

    // Directed table.
    // A lone final byte: done with zero sequence fields.
    add_row(8'h00, 1'b1, 1'b1, 1'b1, mk_hdr(0, 0, 0, 0, 0, 1));
    // Minimal sequence, no literals, offset 0x1234.
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h34, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h12, 1'b0, 1'b1, 1'b1, mk_hdr(1, 0, 0, 4, 16'h1234, 0));
    // One literal, all-ones offset, match extension with one run byte.
    add_row(8'h1F, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hAA, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h05, 1'b0, 1'b1, 1'b1, mk_hdr(1, 3, 1, 39, 16'hFFFF, 0));
    // Sequence cut short inside its literals: dropped, plain done.
    add_row(8'h20, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h22, 1'b1, 1'b1, 1'b1, mk_hdr(0, 0, 0, 0, 0, 1));
    // Final byte also closes a sequence.
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b1, 1'b1, 1'b1, mk_hdr(1, 0, 0, 4, 16'h0201, 1));
    // Literals containing 0xFF, then an extended sequence left open in its
    // literals at the end.
    add_row(8'h30, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hF3, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b1, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].has_hdr, dir_rows[i].hdr);
    drain_headers();

    // Random blocks, with one calm stretch and one full drain midway.
    while (rand_bytes < 280) begin
      calm <= (rand_bytes >= 80 && rand_bytes < 200);
      if (!biggest_done && rand_bytes >= 50) begin
        // Largest match length, with 0xFF closing its capped run.
        blk_bytes.delete();
        build_sequence(1'b1);
        biggest_done = 1'b1;
      end else begin
        make_block();
      end
      send_block(1'b1);
      rand_bytes += blk_bytes.size();
      if (!paused && rand_bytes >= 140) begin
        drain_headers();
        paused = 1'b1;
      end
    end
    calm <= 1'b0;

    // Run past the sequence limit, then end the block normally.
    blk_bytes.delete();
    repeat (MAX_SEQS + 6) build_short_sequence();
    send_block(1'b1);

    // Confirm a clean restart after the limit.
    make_block();
    send_block(1'b1);

    drain_headers();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes; popped %0d sequence headers and %0d end-of-block results,",
             bytes_sent, seqs_seen, dones_seen);
    $display("covering extension caps, truncated sequences and the sequence limit.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: end the run if it hangs.
  initial begin
    #200_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
